### design/assembler_token_splitter_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the assembler token splitter checker
// ---------------------------------------------------------------------------
`ifndef ASSEMBLER_TOKEN_SPLITTER_DEFINES_SVH
`define ASSEMBLER_TOKEN_SPLITTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is low
`define ATS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is low
`define ATS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/ats_pkg.sv
// ---------------------------------------------------------------------------
// ats_pkg
// Types, codes and character constants shared by the token splitter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ats_pkg;

    // Scan modes
    typedef enum logic [2:0] {
        MODE_IDLE       = 3'd0,
        MODE_IDENT      = 3'd1,
        MODE_NUMBER     = 3'd2,
        MODE_STRING     = 3'd3,
        MODE_CHAR_BODY  = 3'd4,
        MODE_CHAR_CLOSE = 3'd5,
        MODE_OPER       = 3'd6
    } mode_t;

    // Token kinds
    typedef enum logic [2:0] {
        KIND_IDENT  = 3'd0,
        KIND_NUMBER = 3'd1,
        KIND_STRING = 3'd2,
        KIND_CHAR   = 3'd3,
        KIND_OPER   = 3'd4,
        KIND_OTHER  = 3'd5
    } kind_t;

    // Error codes
    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_EMPTY_CHAR  = 3'd1,
        ERR_LONG_CHAR   = 3'd2,
        ERR_BAD_NUMBER  = 3'd3,
        ERR_OPEN_STRING = 3'd4,
        ERR_OPEN_CHAR   = 3'd5
    } err_t;

    // Number bases, zero while undecided
    localparam logic [4:0] BASE_NONE = 5'd0;
    localparam logic [4:0] BASE_2    = 5'd2;
    localparam logic [4:0] BASE_8    = 5'd8;
    localparam logic [4:0] BASE_10   = 5'd10;
    localparam logic [4:0] BASE_16   = 5'd16;

    // Characters with a role of their own
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // Per-character classification
    typedef struct packed {
        logic       is_ws;
        logic       is_digit;
        logic       is_id;
        logic       is_op;
        logic       hex_valid;
        logic [3:0] hex_val;
        logic       pfx_ok;
        logic [4:0] pfx_base;
    } char_class_t;

    // Scanner state carried from item to item
    typedef struct packed {
        mode_t      mode;
        logic [4:0] base;
        logic       esc;
        logic [7:0] pend_op;
        err_t       err;
    } scan_state_t;

    // One result item
    typedef struct packed {
        logic [7:0] ch_out;
        logic       in_token;
        logic       begins;
        kind_t      kind;
        err_t       error;
        logic       line_done;
    } result_t;

endpackage

`default_nettype wire

### design/ats_class.sv
// ---------------------------------------------------------------------------
// ats_class
// Character classifier: whitespace, digit, identifier, operator, hex digit
// value and number prefix decode for one byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ats_class
(
    input  wire logic [7:0]          ch,
    output ats_pkg::char_class_t     cls
);

    logic is_lower;
    logic is_upper;
    logic is_dig;

    // Decode character ranges
    always_comb
    begin
        is_lower = (ch >= 8'h61) && (ch <= 8'h7A);
        is_upper = (ch >= 8'h41) && (ch <= 8'h5A);
        is_dig   = (ch >= 8'h30) && (ch <= 8'h39);

        cls.is_ws    = (ch == ats_pkg::CH_SPACE) || (ch == ats_pkg::CH_TAB);
        cls.is_digit = is_dig;
        // letters, digits, underscore and colon
        cls.is_id    = is_lower || is_upper || is_dig || (ch == 8'h5F) || (ch == 8'h3A);
        // ; & | $ % < > = !
        cls.is_op    = (ch == 8'h3B) || (ch == 8'h26) || (ch == 8'h7C) ||
                       (ch == 8'h24) || (ch == 8'h25) || (ch == ats_pkg::CH_LT) ||
                       (ch == ats_pkg::CH_GT) || (ch == ats_pkg::CH_EQ) ||
                       (ch == ats_pkg::CH_BANG);

        // Hex digit value
        cls.hex_valid = 1'b1;
        cls.hex_val   = 4'd0;
        if (is_dig)
        begin
            cls.hex_val = 4'(ch - 8'h30);
        end
        else if ((ch >= 8'h61) && (ch <= 8'h66))
        begin
            cls.hex_val = 4'(ch - 8'h57);
        end
        else if ((ch >= 8'h41) && (ch <= 8'h46))
        begin
            cls.hex_val = 4'(ch - 8'h37);
        end
        else
        begin
            cls.hex_valid = 1'b0;
        end

        // Base chosen by the character after a leading zero
        cls.pfx_ok   = 1'b1;
        cls.pfx_base = ats_pkg::BASE_NONE;
        if ((ch >= 8'h31) && (ch <= 8'h37))
        begin
            cls.pfx_base = ats_pkg::BASE_8;
        end
        else if ((ch == 8'h62) || (ch == 8'h42))
        begin
            cls.pfx_base = ats_pkg::BASE_2;
        end
        else if ((ch == 8'h6F) || (ch == 8'h4F))
        begin
            cls.pfx_base = ats_pkg::BASE_8;
        end
        else if ((ch == 8'h64) || (ch == 8'h44))
        begin
            cls.pfx_base = ats_pkg::BASE_10;
        end
        else if ((ch == 8'h68) || (ch == 8'h48) || (ch == 8'h78) || (ch == 8'h58))
        begin
            cls.pfx_base = ats_pkg::BASE_16;
        end
        else
        begin
            cls.pfx_ok = 1'b0;
        end
    end

endmodule

`default_nettype wire

### design/ats_step.sv
// ---------------------------------------------------------------------------
// ats_step
// Scanner step: from the current state and one classified character, form
// the result item and the state for the next character.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ats_step
(
    input  wire logic [7:0]              ch,
    input  wire logic                    line_end,
    input  wire ats_pkg::char_class_t    cls,
    input  wire ats_pkg::scan_state_t    st,
    output ats_pkg::scan_state_t         nxt,
    output ats_pkg::result_t             res
);

    ats_pkg::scan_state_t s;
    logic [7:0]           co;
    logic                 tok;
    logic                 beg;
    ats_pkg::kind_t       knd;
    logic                 restart;
    logic                 fail;
    ats_pkg::err_t        fail_code;
    logic                 op_pair;

    always_comb
    begin
        s         = st;
        co        = ch;
        tok       = 1'b0;
        beg       = 1'b0;
        knd       = ats_pkg::KIND_OTHER;
        restart   = 1'b0;
        fail      = 1'b0;
        fail_code = ats_pkg::ERR_NONE;
        op_pair   = (ch == st.pend_op) ||
                    ((ch == ats_pkg::CH_EQ) &&
                     ((st.pend_op == ats_pkg::CH_BANG) || (st.pend_op == ats_pkg::CH_LT) ||
                      (st.pend_op == ats_pkg::CH_GT)));

        if (st.err == ats_pkg::ERR_NONE)
        begin
            // Continue the token in progress
            unique case (st.mode)
                ats_pkg::MODE_IDENT:
                begin
                    if (cls.is_id)
                    begin
                        tok = 1'b1;
                        knd = ats_pkg::KIND_IDENT;
                    end
                    else
                    begin
                        restart = 1'b1;
                    end
                end
                ats_pkg::MODE_NUMBER:
                begin
                    if (st.base == ats_pkg::BASE_NONE)
                    begin
                        if (cls.is_ws)
                        begin
                            restart = 1'b1;
                        end
                        else if (cls.pfx_ok)
                        begin
                            s.base = cls.pfx_base;
                            tok    = 1'b1;
                            knd    = ats_pkg::KIND_NUMBER;
                        end
                        else
                        begin
                            fail      = 1'b1;
                            fail_code = ats_pkg::ERR_BAD_NUMBER;
                        end
                    end
                    else if (cls.hex_valid && ({1'b0, cls.hex_val} < st.base))
                    begin
                        tok = 1'b1;
                        knd = ats_pkg::KIND_NUMBER;
                    end
                    else
                    begin
                        restart = 1'b1;
                    end
                end
                ats_pkg::MODE_STRING:
                begin
                    if (ch == ats_pkg::CH_TAB)
                    begin
                        co = ats_pkg::CH_SPACE;
                    end
                    tok = 1'b1;
                    knd = ats_pkg::KIND_STRING;
                    if (st.esc)
                    begin
                        s.esc = 1'b0;
                    end
                    else if (ch == ats_pkg::CH_BSLASH)
                    begin
                        s.esc = 1'b1;
                    end
                    else if (ch == ats_pkg::CH_DQUOTE)
                    begin
                        s.mode = ats_pkg::MODE_IDLE;
                    end
                end
                ats_pkg::MODE_CHAR_BODY:
                begin
                    if (ch == ats_pkg::CH_TAB)
                    begin
                        co = ats_pkg::CH_SPACE;
                    end
                    if (st.esc)
                    begin
                        s.esc  = 1'b0;
                        s.mode = ats_pkg::MODE_CHAR_CLOSE;
                        tok    = 1'b1;
                        knd    = ats_pkg::KIND_CHAR;
                    end
                    else if (ch == ats_pkg::CH_SQUOTE)
                    begin
                        fail      = 1'b1;
                        fail_code = ats_pkg::ERR_EMPTY_CHAR;
                    end
                    else if (ch == ats_pkg::CH_BSLASH)
                    begin
                        s.esc = 1'b1;
                        tok   = 1'b1;
                        knd   = ats_pkg::KIND_CHAR;
                    end
                    else
                    begin
                        s.mode = ats_pkg::MODE_CHAR_CLOSE;
                        tok    = 1'b1;
                        knd    = ats_pkg::KIND_CHAR;
                    end
                end
                ats_pkg::MODE_CHAR_CLOSE:
                begin
                    if (ch == ats_pkg::CH_TAB)
                    begin
                        co = ats_pkg::CH_SPACE;
                    end
                    if (ch == ats_pkg::CH_SQUOTE)
                    begin
                        s.mode = ats_pkg::MODE_IDLE;
                        tok    = 1'b1;
                        knd    = ats_pkg::KIND_CHAR;
                    end
                    else
                    begin
                        fail      = 1'b1;
                        fail_code = ats_pkg::ERR_LONG_CHAR;
                    end
                end
                ats_pkg::MODE_OPER:
                begin
                    if (op_pair)
                    begin
                        tok       = 1'b1;
                        knd       = ats_pkg::KIND_OPER;
                        s.mode    = ats_pkg::MODE_IDLE;
                        s.pend_op = 8'd0;
                    end
                    else
                    begin
                        restart = 1'b1;
                    end
                end
                default:
                begin
                    restart = 1'b1;
                end
            endcase

            // Latch the error and drop the token in progress
            if (fail)
            begin
                s.err     = fail_code;
                s.mode    = ats_pkg::MODE_IDLE;
                s.esc     = 1'b0;
                s.pend_op = 8'd0;
                s.base    = ats_pkg::BASE_NONE;
                tok       = 1'b0;
                beg       = 1'b0;
                knd       = ats_pkg::KIND_OTHER;
            end

            // Start a new token on this character, or skip it if it is whitespace
            if (restart)
            begin
                s.mode    = ats_pkg::MODE_IDLE;
                s.esc     = 1'b0;
                s.pend_op = 8'd0;
                s.base    = ats_pkg::BASE_NONE;
                if (!cls.is_ws)
                begin
                    beg = 1'b1;
                    tok = 1'b1;
                    if (ch == ats_pkg::CH_DQUOTE)
                    begin
                        knd    = ats_pkg::KIND_STRING;
                        s.mode = ats_pkg::MODE_STRING;
                    end
                    else if (ch == ats_pkg::CH_SQUOTE)
                    begin
                        knd    = ats_pkg::KIND_CHAR;
                        s.mode = ats_pkg::MODE_CHAR_BODY;
                    end
                    else if (cls.is_digit)
                    begin
                        knd    = ats_pkg::KIND_NUMBER;
                        s.mode = ats_pkg::MODE_NUMBER;
                        s.base = (ch == ats_pkg::CH_ZERO) ? ats_pkg::BASE_NONE
                                                          : ats_pkg::BASE_10;
                    end
                    else if (cls.is_id || (ch == ats_pkg::CH_DOT))
                    begin
                        knd    = ats_pkg::KIND_IDENT;
                        s.mode = ats_pkg::MODE_IDENT;
                    end
                    else if (cls.is_op)
                    begin
                        knd       = ats_pkg::KIND_OPER;
                        s.mode    = ats_pkg::MODE_OPER;
                        s.pend_op = ch;
                    end
                    else
                    begin
                        knd = ats_pkg::KIND_OTHER;
                    end
                end
            end

            // Flag a quote left open at line end
            if (line_end && (s.err == ats_pkg::ERR_NONE))
            begin
                if (s.mode == ats_pkg::MODE_STRING)
                begin
                    s.err = ats_pkg::ERR_OPEN_STRING;
                end
                else if ((s.mode == ats_pkg::MODE_CHAR_BODY) ||
                         (s.mode == ats_pkg::MODE_CHAR_CLOSE))
                begin
                    s.err = ats_pkg::ERR_OPEN_CHAR;
                end
            end
        end

        res.ch_out    = co;
        res.in_token  = tok;
        res.begins    = beg;
        res.kind      = knd;
        res.error     = s.err;
        res.line_done = line_end;

        // Return to idle after the last character of a line
        if (line_end)
        begin
            nxt.mode    = ats_pkg::MODE_IDLE;
            nxt.base    = ats_pkg::BASE_NONE;
            nxt.esc     = 1'b0;
            nxt.pend_op = 8'd0;
            nxt.err     = ats_pkg::ERR_NONE;
        end
        else
        begin
            nxt = s;
        end
    end

endmodule

`default_nettype wire

### design/assembler_token_splitter.sv
// ---------------------------------------------------------------------------
// assembler_token_splitter
// Splits an assembler line, one character per item, into token fields.
// ---------------------------------------------------------------------------
// Input channel: ch and line_end with in_valid / in_stall; the item is taken
// at a clock edge with in_valid high and in_stall low. Mark the last
// character of every line with line_end.
// Output channel: ch_out, in_token, begins, kind, error and line_done with
// out_valid / out_stall; one result item per input item, in order.
// Path: an item goes from the input register through the scanner step to the
// result register, where out_valid rises; out_stall can hold it in the input
// register. Throughput: one item per cycle while out_stall is low, set by the
// single scanner state update between the two registers.
// Stall: while out_stall holds a result, the input register still takes one
// more item; in_stall rises only when both registers are full.
// Reset: rst_n clears both valid flags and returns the scanner to idle with
// no error. Scanner state also returns to idle after each line_end item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module assembler_token_splitter
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  ch,
    input  wire logic        line_end,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       ch_out,
    output logic             in_token,
    output logic             begins,
    output logic [2:0]       kind,
    output logic [2:0]       error,
    output logic             line_done
);

    logic                  in_valid_reg;
    logic [7:0]            ch_reg;
    logic                  line_end_reg;
    logic                  out_valid_reg;
    ats_pkg::result_t      result_reg;
    ats_pkg::result_t      result_next;
    ats_pkg::scan_state_t  state_reg;
    ats_pkg::scan_state_t  state_next;
    ats_pkg::char_class_t  cls;
    logic                  out_ready;
    logic                  advance;
    logic                  in_take;

    // Handshake: result stage frees when empty or taken
    assign out_ready = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && out_ready;
    assign in_stall  = in_valid_reg && !out_ready;
    assign in_take   = in_valid && !in_stall;

    // Classify the held character
    ats_class u_class
    (
        .ch  (ch_reg),
        .cls (cls)
    );

    // Scanner step
    ats_step u_step
    (
        .ch       (ch_reg),
        .line_end (line_end_reg),
        .cls      (cls),
        .st       (state_reg),
        .nxt      (state_next),
        .res      (result_next)
    );

    // Valid flags and scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            state_reg.mode    <= ats_pkg::MODE_IDLE;
            state_reg.base    <= ats_pkg::BASE_NONE;
            state_reg.esc     <= 1'b0;
            state_reg.pend_op <= 8'd0;
            state_reg.err     <= ats_pkg::ERR_NONE;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (out_ready)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ch_reg       <= ch;
            line_end_reg <= line_end;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    // Drive result ports
    assign out_valid = out_valid_reg;
    assign ch_out    = result_reg.ch_out;
    assign in_token  = result_reg.in_token;
    assign begins    = result_reg.begins;
    assign kind      = result_reg.kind;
    assign error     = result_reg.error;
    assign line_done = result_reg.line_done;

endmodule

`default_nettype wire

### design/ats_checker.sv
// ---------------------------------------------------------------------------
// ats_checker
// Port-level checks on the token splitter result channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assembler_token_splitter_defines.svh"

module ats_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [7:0]  ch_out,
    input  wire logic        in_token,
    input  wire logic        begins,
    input  wire logic [2:0]  kind,
    input  wire logic [2:0]  error,
    input  wire logic        line_done
);

    // A token start is always part of a token
    `ATS_ASSERT_NOW(a_begin_in_token, out_valid && begins, in_token, "begins without in_token")

    // Separating and error characters carry the other kind
    `ATS_ASSERT_NOW(a_gap_kind, out_valid && !in_token, kind == ats_pkg::KIND_OTHER, "gap kind wrong")

    // An open quote error appears only on the last character of the line
    `ATS_ASSERT_NOW(a_open_at_end, out_valid && ((error == ats_pkg::ERR_OPEN_STRING) || (error == ats_pkg::ERR_OPEN_CHAR)), line_done, "open quote error before line end")

    // A stalled result holds
    `ATS_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(ch_out) && $stable(error), "stalled result changed")

endmodule

bind assembler_token_splitter ats_checker u_ats_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ch_out    (ch_out),
    .in_token  (in_token),
    .begins    (begins),
    .kind      (kind),
    .error     (error),
    .line_done (line_done)
);

`default_nettype wire

### dv/assembler_token_splitter_test.sv
// ---------------------------------------------------------------------------
// assembler_token_splitter_test
// Self-checking testbench for the assembler token splitter. Lines of
// characters go in one item at a time; every result item is compared field
// by field against a scanner model kept in the bench. Covers hand-picked
// corner lines, random well-formed and broken lines, a long output stall
// that backs up the input, and a final stretch at full rate.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module assembler_token_splitter_test;

    localparam int HALF_PERIOD   = 1;
    localparam int RESET_CYCLES  = 7;
    localparam int RANDOM_ITEMS  = 900;
    localparam int HOLD_CYCLES   = 200;
    localparam int FULL_RATE_ITEMS = 120;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 200000;

    // Character sets for the line generator
    localparam string WORD_CHARS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_:";
    localparam string DEC_DIGITS = "0123456789";
    localparam string HEX_DIGITS = "0123456789abcdefABCDEF";
    localparam string BASE_MARKS = "bBoOdDhHxX";
    localparam string OPER_SET   = ";&|$%<>=!";
    localparam string PUNCT_SET  = "()[],+-*/#@~^?{}";
    localparam string BLANK_SET  = " \t";

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] ch = 8'h00;
    logic       line_end = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] ch_out;
    logic       in_token;
    logic       begins;
    logic [2:0] kind;
    logic [2:0] error;
    logic       line_done;

    // Scanner model state and expected results
    ats_pkg::scan_state_t scan;
    ats_pkg::result_t     expected_tokens[$];
    logic [7:0]           line_chars[$];

    // Idle control and bookkeeping
    bit src_idle_en  = 1'b0;
    bit sink_idle_en = 1'b0;
    int hold_requests = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int sink_gap      = 0;
    int cycle_count   = 0;
    int input_stall_cycles = 0;
    int chars_sent    = 0;
    int lines_sent    = 0;
    int results_checked = 0;
    int lines_with_error = 0;
    int mismatch_count = 0;

    assembler_token_splitter uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .ch        (ch),
        .line_end  (line_end),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ch_out    (ch_out),
        .in_token  (in_token),
        .begins    (begins),
        .kind      (kind),
        .error     (error),
        .line_done (line_done)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // Character classes
    // ------------------------------------------------------------------
    function automatic bit is_blank(input logic [7:0] c);
        return c == ats_pkg::CH_SPACE || c == ats_pkg::CH_TAB;
    endfunction

    function automatic bit is_word(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || c == "_" || c == ":";
    endfunction

    function automatic bit is_oper(input logic [7:0] c);
        case (c)
            ";", "&", "|", "$", "%", "<", ">", "=", "!": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic int digit_val(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return 99;
    endfunction

    // Base chosen by the character after a leading zero
    function automatic logic [4:0] prefix_base(input logic [7:0] c);
        if (c >= "1" && c <= "7") return ats_pkg::BASE_8;
        case (c)
            "b", "B": return ats_pkg::BASE_2;
            "o", "O": return ats_pkg::BASE_8;
            "d", "D": return ats_pkg::BASE_10;
            "h", "H", "x", "X": return ats_pkg::BASE_16;
            default: return ats_pkg::BASE_NONE;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Scanner model
    // ------------------------------------------------------------------
    task automatic clear_scan();
        scan.mode    = ats_pkg::MODE_IDLE;
        scan.base    = ats_pkg::BASE_NONE;
        scan.esc     = 1'b0;
        scan.pend_op = 8'h00;
        scan.err     = ats_pkg::ERR_NONE;
    endtask

    // Latch an error; token fields stay at their not-in-token defaults
    task automatic latch_error(input ats_pkg::err_t code);
        scan.err     = code;
        scan.mode    = ats_pkg::MODE_IDLE;
        scan.esc     = 1'b0;
        scan.pend_op = 8'h00;
        scan.base    = ats_pkg::BASE_NONE;
    endtask

    // Advance the model by one character and queue the expected result
    task automatic predict_token(input logic [7:0] c, input logic le);
        ats_pkg::result_t r;
        logic             restart;
        logic [4:0]       pb;
        r.ch_out    = c;
        r.in_token  = 1'b0;
        r.begins    = 1'b0;
        r.kind      = ats_pkg::KIND_OTHER;
        r.error     = ats_pkg::ERR_NONE;
        r.line_done = le;
        restart     = 1'b0;
        if (scan.err == ats_pkg::ERR_NONE)
        begin
            case (scan.mode)
                ats_pkg::MODE_IDENT:
                    if (is_word(c))
                    begin
                        r.in_token = 1'b1;
                        r.kind     = ats_pkg::KIND_IDENT;
                    end
                    else
                        restart = 1'b1;
                ats_pkg::MODE_NUMBER:
                    if (scan.base == ats_pkg::BASE_NONE)
                    begin
                        pb = prefix_base(c);
                        if (is_blank(c))
                            restart = 1'b1;
                        else if (pb != ats_pkg::BASE_NONE)
                        begin
                            scan.base  = pb;
                            r.in_token = 1'b1;
                            r.kind     = ats_pkg::KIND_NUMBER;
                        end
                        else
                            latch_error(ats_pkg::ERR_BAD_NUMBER);
                    end
                    else if (digit_val(c) < int'(scan.base))
                    begin
                        r.in_token = 1'b1;
                        r.kind     = ats_pkg::KIND_NUMBER;
                    end
                    else
                        restart = 1'b1;
                ats_pkg::MODE_STRING:
                begin
                    if (c == ats_pkg::CH_TAB) r.ch_out = ats_pkg::CH_SPACE;
                    r.in_token = 1'b1;
                    r.kind     = ats_pkg::KIND_STRING;
                    if (scan.esc)
                        scan.esc = 1'b0;
                    else if (c == ats_pkg::CH_BSLASH)
                        scan.esc = 1'b1;
                    else if (c == ats_pkg::CH_DQUOTE)
                        scan.mode = ats_pkg::MODE_IDLE;
                end
                ats_pkg::MODE_CHAR_BODY:
                begin
                    if (c == ats_pkg::CH_TAB) r.ch_out = ats_pkg::CH_SPACE;
                    if (scan.esc)
                    begin
                        scan.esc   = 1'b0;
                        scan.mode  = ats_pkg::MODE_CHAR_CLOSE;
                        r.in_token = 1'b1;
                        r.kind     = ats_pkg::KIND_CHAR;
                    end
                    else if (c == ats_pkg::CH_SQUOTE)
                        latch_error(ats_pkg::ERR_EMPTY_CHAR);
                    else
                    begin
                        if (c == ats_pkg::CH_BSLASH)
                            scan.esc = 1'b1;
                        else
                            scan.mode = ats_pkg::MODE_CHAR_CLOSE;
                        r.in_token = 1'b1;
                        r.kind     = ats_pkg::KIND_CHAR;
                    end
                end
                ats_pkg::MODE_CHAR_CLOSE:
                begin
                    if (c == ats_pkg::CH_TAB) r.ch_out = ats_pkg::CH_SPACE;
                    if (c == ats_pkg::CH_SQUOTE)
                    begin
                        scan.mode  = ats_pkg::MODE_IDLE;
                        r.in_token = 1'b1;
                        r.kind     = ats_pkg::KIND_CHAR;
                    end
                    else
                        latch_error(ats_pkg::ERR_LONG_CHAR);
                end
                ats_pkg::MODE_OPER:
                    if (c == scan.pend_op || (c == ats_pkg::CH_EQ &&
                        (scan.pend_op == ats_pkg::CH_BANG ||
                         scan.pend_op == ats_pkg::CH_LT || scan.pend_op == ats_pkg::CH_GT)))
                    begin
                        r.in_token   = 1'b1;
                        r.kind       = ats_pkg::KIND_OPER;
                        scan.mode    = ats_pkg::MODE_IDLE;
                        scan.pend_op = 8'h00;
                    end
                    else
                        restart = 1'b1;
                default:
                    restart = 1'b1;
            endcase

            // Start a new token, or skip separating whitespace
            if (restart)
            begin
                scan.mode    = ats_pkg::MODE_IDLE;
                scan.esc     = 1'b0;
                scan.pend_op = 8'h00;
                scan.base    = ats_pkg::BASE_NONE;
                if (!is_blank(c))
                begin
                    r.begins   = 1'b1;
                    r.in_token = 1'b1;
                    if (c == ats_pkg::CH_DQUOTE)
                    begin
                        r.kind    = ats_pkg::KIND_STRING;
                        scan.mode = ats_pkg::MODE_STRING;
                    end
                    else if (c == ats_pkg::CH_SQUOTE)
                    begin
                        r.kind    = ats_pkg::KIND_CHAR;
                        scan.mode = ats_pkg::MODE_CHAR_BODY;
                    end
                    else if (c >= "0" && c <= "9")
                    begin
                        r.kind    = ats_pkg::KIND_NUMBER;
                        scan.mode = ats_pkg::MODE_NUMBER;
                        scan.base = (c == ats_pkg::CH_ZERO) ? ats_pkg::BASE_NONE
                                                            : ats_pkg::BASE_10;
                    end
                    else if (is_word(c) || c == ats_pkg::CH_DOT)
                    begin
                        r.kind    = ats_pkg::KIND_IDENT;
                        scan.mode = ats_pkg::MODE_IDENT;
                    end
                    else if (is_oper(c))
                    begin
                        r.kind       = ats_pkg::KIND_OPER;
                        scan.mode    = ats_pkg::MODE_OPER;
                        scan.pend_op = c;
                    end
                    else
                        r.kind = ats_pkg::KIND_OTHER;
                end
            end

            // Flag a quote left open at line end
            if (le && scan.err == ats_pkg::ERR_NONE)
            begin
                if (scan.mode == ats_pkg::MODE_STRING)
                    scan.err = ats_pkg::ERR_OPEN_STRING;
                else if (scan.mode == ats_pkg::MODE_CHAR_BODY ||
                         scan.mode == ats_pkg::MODE_CHAR_CLOSE)
                    scan.err = ats_pkg::ERR_OPEN_CHAR;
            end
        end
        r.error = scan.err;
        expected_tokens.insert(expected_tokens.size(), r);
        if (le)
        begin
            if (scan.err != ats_pkg::ERR_NONE) lines_with_error++;
            lines_sent++;
            clear_scan();
        end
    endtask

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    task automatic send_char(input logic [7:0] c, input logic le);
        int gap;
        // Insert an idle burst now and then
        if (src_idle_en && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        ch       <= c;
        line_end <= le;
        do @(posedge clk); while (in_stall);
        predict_token(c, le);
        chars_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s, input logic le);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], le && (i == s.len() - 1));
    endtask

    // ------------------------------------------------------------------
    // Line generator
    // ------------------------------------------------------------------
    function automatic logic [7:0] pick(input string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    function automatic string digits_for(input logic [7:0] mark);
        case (mark)
            "b", "B": return "01";
            "o", "O": return "01234567";
            "d", "D": return DEC_DIGITS;
            default: return HEX_DIGITS;
        endcase
    endfunction

    // Any byte except the closing quote and backslash
    function automatic logic [7:0] quoted_byte(input logic [7:0] quote);
        logic [7:0] b;
        b = ($urandom_range(0, 5) == 0) ? ats_pkg::CH_TAB : 8'($urandom_range(0, 255));
        if (b == quote || b == ats_pkg::CH_BSLASH) b = "a";
        return b;
    endfunction

    // Add one character to the line being built
    task automatic append_char(input logic [7:0] c);
        line_chars.insert(line_chars.size(), c);
    endtask

    task automatic add_good_token();
        logic [7:0] mark;
        int         n;
        n = $urandom_range(0, 5);
        case ($urandom_range(0, 8))
            0:
            begin
                append_char(($urandom_range(0, 5) == 0) ? ats_pkg::CH_DOT : pick(WORD_CHARS));
                repeat (n) append_char(pick({WORD_CHARS, DEC_DIGITS}));
            end
            1:
            begin
                append_char(pick("123456789"));
                repeat (n) append_char(pick(DEC_DIGITS));
            end
            2:
            begin
                mark = pick(BASE_MARKS);
                append_char(ats_pkg::CH_ZERO);
                append_char(mark);
                repeat (n) append_char(pick(digits_for(mark)));
            end
            3:
            begin
                append_char(ats_pkg::CH_ZERO);
                append_char(pick("1234567"));
                repeat (n) append_char(pick("01234567"));
            end
            4:
                append_char(ats_pkg::CH_ZERO);
            5:
            begin
                append_char(ats_pkg::CH_DQUOTE);
                repeat (n)
                begin
                    if ($urandom_range(0, 5) == 0)
                    begin
                        append_char(ats_pkg::CH_BSLASH);
                        append_char(8'($urandom_range(0, 255)));
                    end
                    else
                        append_char(quoted_byte(ats_pkg::CH_DQUOTE));
                end
                append_char(ats_pkg::CH_DQUOTE);
            end
            6:
            begin
                append_char(ats_pkg::CH_SQUOTE);
                if ($urandom_range(0, 3) == 0)
                begin
                    append_char(ats_pkg::CH_BSLASH);
                    append_char(8'($urandom_range(0, 255)));
                end
                else
                    append_char(quoted_byte(ats_pkg::CH_SQUOTE));
                append_char(ats_pkg::CH_SQUOTE);
            end
            7:
                case ($urandom_range(0, 2))
                    0: append_char(pick(OPER_SET));
                    1:
                    begin
                        mark = pick(OPER_SET);
                        append_char(mark);
                        append_char(mark);
                    end
                    default:
                    begin
                        append_char(pick("!<>"));
                        append_char(ats_pkg::CH_EQ);
                    end
                endcase
            default:
                append_char(pick(PUNCT_SET));
        endcase
    endtask

    task automatic add_broken_token();
        case ($urandom_range(0, 4))
            0:
            begin
                append_char(ats_pkg::CH_SQUOTE);
                append_char(ats_pkg::CH_SQUOTE);
            end
            1:
            begin
                append_char(ats_pkg::CH_SQUOTE);
                append_char(pick(WORD_CHARS));
                append_char(pick(WORD_CHARS));
                append_char(ats_pkg::CH_SQUOTE);
            end
            2:
            begin
                append_char(ats_pkg::CH_ZERO);
                append_char(pick("gqzZ9.!_"));
            end
            default:
                repeat ($urandom_range(1, 4)) append_char(8'($urandom_range(0, 255)));
        endcase
    endtask

    // Build one line of tokens, mostly well formed, and send it
    task automatic send_random_line();
        int tokens;
        tokens = $urandom_range(1, 6);
        line_chars.delete();
        if ($urandom_range(0, 4) == 0) append_char(pick(BLANK_SET));
        for (int t = 0; t < tokens; t++)
        begin
            if ($urandom_range(0, 9) == 0)
                add_broken_token();
            else
                add_good_token();
            // Separate with blanks most of the time
            if ($urandom_range(0, 4) != 0)
                repeat ($urandom_range(1, 2)) append_char(pick(BLANK_SET));
        end
        // Leave a quote open at the end once in a while
        if ($urandom_range(0, 9) == 0)
            append_char(($urandom_range(0, 1) != 0) ? ats_pkg::CH_DQUOTE : ats_pkg::CH_SQUOTE);
        foreach (line_chars[i])
            send_char(line_chars[i], i == line_chars.size() - 1);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall bursts plus a long hold on request
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_seen != hold_requests)
        begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (sink_gap > 0)
        begin
            sink_gap--;
            out_stall <= 1'b1;
        end
        else if (sink_idle_en && $urandom_range(0, 7) == 0)
        begin
            sink_gap = $urandom_range(0, 11);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("ERROR: result %0d: %s got 0x%0h expected 0x%0h",
                 results_checked, what, got, want);
    endtask

    always @(posedge clk)
    begin : check_results
        ats_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_tokens.size() == 0)
                report_mismatch("unexpected result, ch_out", ch_out, 0);
            else
            begin
                want = expected_tokens.pop_front();
                if (ch_out !== want.ch_out)
                    report_mismatch("ch_out", ch_out, want.ch_out);
                if (in_token !== want.in_token)
                    report_mismatch("in_token", in_token, want.in_token);
                if (begins !== want.begins)
                    report_mismatch("begins", begins, want.begins);
                if (kind !== want.kind)
                    report_mismatch("kind", kind, want.kind);
                if (error !== want.error)
                    report_mismatch("error", error, want.error);
                if (line_done !== want.line_done)
                    report_mismatch("line_done", line_done, want.line_done);
            end
            results_checked++;
        end
    end

    // Count cycles, note input backpressure, and stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (in_valid && in_stall) input_stall_cycles++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_tokens.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_corner_lines();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        // leading digit, dot starting an identifier
        send_text("9a.1", 1'b1);
        // lone zero before a blank, H as hex base letter
        send_text("0 0Hf", 1'b1);
        // compare operator, tab inside an unterminated string
        send_text("!=\"\t", 1'b1);
        // bad number on the last character of the line
        send_text("0z", 1'b1);
        // zero byte and all-ones byte, then an open char literal
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_text("'", 1'b1);
        // empty char literal
        send_text("''x", 1'b1);
        // char literal too long
        send_text("'ab", 1'b1);
    endtask

    task automatic test_random_lines();
        int stop_at;
        stop_at      = chars_sent + RANDOM_ITEMS;
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        while (chars_sent < stop_at) send_random_line();
    endtask

    // Hold the output for a long stretch while the input keeps offering
    task automatic test_output_hold();
        int stop_at;
        stop_at      = chars_sent + 60;
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        hold_requests++;
        while (chars_sent < stop_at) send_random_line();
    endtask

    task automatic test_full_rate();
        int stop_at;
        stop_at      = chars_sent + FULL_RATE_ITEMS;
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        while (chars_sent < stop_at) send_random_line();
    endtask

    initial
    begin
        clear_scan();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_corner_lines();
        test_random_lines();
        test_output_hold();
        test_full_rate();

        // Drain outstanding results
        in_valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d characters in %0d lines; %0d lines ended with an error.",
                 chars_sent, lines_sent, lines_with_error);
        $display("Checked %0d results; input held off for %0d cycles.",
                 results_checked, input_stall_cycles);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### assembler_token_splitter.f
+incdir+design
design/ats_pkg.sv
design/ats_class.sv
design/ats_step.sv
design/assembler_token_splitter.sv
design/ats_checker.sv
dv/assembler_token_splitter_test.sv
